// ===== sv/mlp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the perceptron trainer.
package mlp_pkg;

    localparam int B_W        = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_KP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_FLOOR    = 3'd4;

    localparam logic [15:0] GAIN_KP_RST   = 16'd2621;
    localparam logic [6:0]  OFFSET_RST    = 7'd20;
    localparam logic [15:0] INIT_RATE_RST = 16'd19661;
    localparam logic [15:0] RATE_STEP_RST = 16'd131;
    localparam logic [15:0] RATE_FLOOR_RST = 16'd328;

    localparam int SIG_SAT   = 327680;
    localparam int SIG_KNEE2 = 155648;
    localparam int SIG_KNEE1 = 65536;
    localparam logic [16:0] SIG_ONE  = 17'd65536;
    localparam logic [16:0] SIG_OFS2 = 17'd55296;
    localparam logic [16:0] SIG_OFS1 = 17'd40960;
    localparam logic [16:0] SIG_OFS0 = 17'd32768;

    localparam logic [6:0]  SPEED_MAX = 7'd100;
    localparam logic [25:0] T_RECIP   = 26'd42949673;

    typedef enum logic [1:0] {
        ACT_INFER = 2'd0,
        ACT_TRAIN = 2'd1,
        ACT_EPOCH = 2'd2,
        ACT_LOAD  = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        S_IDLE,
        S_HID,
        S_HACT,
        S_OSUM,
        S_OACT,
        S_TGT,
        S_DP,
        S_DD,
        S_ERR,
        S_HQ,
        S_HG,
        S_HS,
        S_HW,
        S_HB,
        S_OS,
        S_OW,
        S_OB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clr;
    } t_mac_ctl;

    typedef struct packed {
        logic we;
        logic sub;
    } t_wr_ctl;

endpackage

// ===== sv/mlp_mac.sv =====
`timescale 1ns / 1ps
// Shared multiplier with product register and accumulator.
module mlp_mac #(
    parameter int A_W   = 26,
    parameter int ACC_W = 48
) (
    input  logic                                 i_clk,
    input  mlp_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [A_W-1:0]                i_a,
    input  logic signed [mlp_pkg::B_W-1:0]       i_b,
    output logic signed [A_W+mlp_pkg::B_W-1:0]   o_prod,
    output logic signed [ACC_W-1:0]              o_acc
);
    import mlp_pkg::*;

    localparam int P_W = A_W + B_W;

    logic signed [P_W-1:0]   r_prod, n_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    always_comb begin
        n_prod = r_prod;
        if (i_ctl.mul_en) begin
            n_prod = i_a * i_b;
        end
        n_acc = r_acc;
        if (i_ctl.acc_en) begin
            if (i_ctl.acc_clr) begin
                n_acc = ACC_W'(r_prod);
            end else begin
                n_acc = r_acc + ACC_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// ===== sv/mlp_wmem.sv =====
`timescale 1ns / 1ps
// Weight register file with saturating load and subtract-update write port.
module mlp_wmem #(
    parameter int W_BITS = 24,
    parameter int DEPTH  = 17,
    parameter int D_W    = 34
) (
    input  logic                       i_clk,
    input  mlp_pkg::t_wr_ctl           i_ctl,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    input  logic signed [D_W-1:0]      i_data,
    output logic signed [W_BITS-1:0]   o_rdata
);
    import mlp_pkg::*;

    localparam logic signed [D_W-1:0] W_MAX =
        {{(D_W-W_BITS+1){1'b0}}, {(W_BITS-1){1'b1}}};
    localparam logic signed [D_W-1:0] W_MIN =
        {{(D_W-W_BITS+1){1'b1}}, {(W_BITS-1){1'b0}}};

    logic signed [W_BITS-1:0] r_mem [DEPTH];
    logic signed [D_W-1:0]    w_ext;
    logic signed [D_W-1:0]    w_sum;
    logic signed [W_BITS-1:0] w_sat;

    assign o_rdata = r_mem[i_addr];

    always_comb begin
        w_ext = D_W'(o_rdata);
        w_sum = i_ctl.sub ? (w_ext - i_data) : i_data;
        if (w_sum > W_MAX) begin
            w_sat = W_MAX[W_BITS-1:0];
        end else if (w_sum < W_MIN) begin
            w_sat = W_MIN[W_BITS-1:0];
        end else begin
            w_sat = w_sum[W_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= w_sat;
        end
    end

endmodule

// ===== sv/mlp_two_three_two_backprop.sv =====
`timescale 1ns / 1ps
// Top level of the sigmoid perceptron with backpropagation training.
// One input beat is handled at a time; the input is not ready until its result beat has been
// placed in the output register, which can hold one finished result while the next beat is
// taken. Load and epoch beats go straight to the result. Every product goes through a single
// shared multiplier (multiply, then accumulate or store). Weights are undefined until loaded.
module mlp_two_three_two_backprop #(
    parameter int HIDDEN_NODES = 3,
    parameter int WEIGHT_BITS  = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_action,
    input  logic [7:0]                          i_left_reading,
    input  logic [7:0]                          i_right_reading,
    input  logic [4:0]                          i_weight_index,
    input  logic signed [23:0]                  i_weight_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [6:0]                          o_left_speed,
    output logic [6:0]                          o_right_speed,
    output logic [15:0]                         o_current_rate,
    input  logic                                i_cfg_we,
    input  logic [mlp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mlp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mlp_pkg::*;

    localparam int H     = HIDDEN_NODES;
    localparam int W     = WEIGHT_BITS;
    localparam int SLOTS = 5 * H + 2;
    localparam int AD_W  = $clog2(SLOTS);
    localparam int A_W   = W + 2;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = W + 24;
    localparam int Z_W   = ACC_W - 15;
    localparam int D_W   = W + 10;
    localparam int J_W   = (H > 1) ? $clog2(H) : 1;
    localparam logic [J_W-1:0] J_LAST = J_W'(H - 1);

    t_state  r_state, n_state;
    logic    r_ph, n_ph;
    logic    r_i, n_i;
    logic    r_k, n_k;
    logic [J_W-1:0] r_j, n_j;

    t_action r_act;
    logic [7:0]  r_l, r_r;
    logic [15:0] r_h [H];
    logic [15:0] r_o [2];
    logic [15:0] r_t [2];
    logic [6:0]  r_spd [2];
    logic signed [15:0] r_d [2];
    logic [14:0] r_p;
    logic signed [A_W-1:0] r_g, r_s;

    logic [15:0] r_lr, r_kp, r_init, r_step, r_floor;
    logic [6:0]  r_off;

    logic        r_ov;
    logic [6:0]  r_out_l, r_out_r;
    logic [15:0] r_out_rate;

    logic        w_accept;
    logic        w_push;
    logic        w_idx_ok;
    t_mac_ctl    w_mac;
    t_wr_ctl     w_wr;
    logic signed [A_W-1:0]   w_a;
    logic signed [B_W-1:0]   w_b;
    logic signed [P_W-1:0]   w_prod;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [P_W-17:0]  w_prod_hi;
    logic signed [ACC_W-17:0] w_acc_hi;
    logic signed [W-1:0]     w_rdata;
    logic [AD_W-1:0]         w_addr;
    logic signed [D_W-1:0]   w_wdata;
    logic signed [Z_W-1:0]   w_z;
    logic [15:0]             w_sig;
    logic [22:0]             w_spd;
    logic [15:0]             w_x;
    logic [15:0]             w_oi;
    logic [15:0]             w_hj;
    logic signed [26:0]      w_off, w_ke;
    int                      w_sel;

    function automatic logic [15:0] f_sigm(input logic signed [Z_W-1:0] z);
        logic [Z_W-1:0] m;
        logic [16:0]    y;
        m = z[Z_W-1] ? $unsigned(-z) : $unsigned(z);
        if (m >= Z_W'(SIG_SAT)) begin
            y = SIG_ONE;
        end else if (m >= Z_W'(SIG_KNEE2)) begin
            y = 17'(m[18:5]) + SIG_OFS2;
        end else if (m >= Z_W'(SIG_KNEE1)) begin
            y = 17'(m[18:3]) + SIG_OFS1;
        end else begin
            y = 17'(m[18:2]) + SIG_OFS0;
        end
        if (z[Z_W-1]) begin
            y = SIG_ONE - y;
        end
        return y[16] ? 16'hFFFF : y[15:0];
    endfunction

    function automatic logic [15:0] f_target(input logic signed [26:0] v);
        logic [6:0]  sp;
        logic [32:0] q;
        if (v[26]) begin
            sp = 7'd0;
        end else if (v[26:16] > 11'(SPEED_MAX)) begin
            sp = SPEED_MAX;
        end else begin
            sp = v[22:16];
        end
        q = 33'(sp) * 33'(T_RECIP);
        return q[32] ? 16'hFFFF : q[31:16];
    endfunction

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_push   = (r_state == S_DONE) && (!r_ov || i_ready);
    assign w_idx_ok = ({27'd0, i_weight_index} < 32'(SLOTS));

    assign w_prod_hi = $signed(w_prod[P_W-1:16]);
    assign w_acc_hi  = $signed(w_acc[ACC_W-1:16]);
    assign w_z       = Z_W'(w_acc_hi) + Z_W'(w_rdata);
    assign w_sig     = f_sigm(w_z);
    assign w_spd     = 23'(w_sig) * 23'd100;
    assign w_x       = r_k ? {r_r, r_r} : {r_l, r_l};
    assign w_oi      = r_o[r_i];
    assign w_hj      = r_h[r_j];
    assign w_off     = $signed({4'b0, r_off, 16'b0});
    assign w_ke      = $signed(w_prod[26:0]);

    mlp_mac #(
        .A_W   (A_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod),
        .o_acc  (w_acc)
    );

    mlp_wmem #(
        .W_BITS (W),
        .DEPTH  (SLOTS),
        .D_W    (D_W)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_ctl   (w_wr),
        .i_addr  (w_addr),
        .i_data  (w_wdata),
        .o_rdata (w_rdata)
    );

    // Next state and loop counters.
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ph = 1'b0;
                    n_i  = 1'b0;
                    n_j  = '0;
                    n_k  = 1'b0;
                    if (i_action == ACT_LOAD || i_action == ACT_EPOCH) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_HID;
                    end
                end
            end
            S_HACT: begin
                if (r_j == J_LAST) begin
                    n_j     = '0;
                    n_state = S_OSUM;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_HID;
                end
            end
            S_OACT: begin
                if (r_i) begin
                    n_i     = 1'b0;
                    n_state = (r_act == ACT_TRAIN) ? S_TGT : S_DONE;
                end else begin
                    n_i     = 1'b1;
                    n_state = S_OSUM;
                end
            end
            S_HB: begin
                if (r_j == J_LAST) begin
                    n_j     = '0;
                    n_state = S_OS;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_ERR;
                end
            end
            S_OB: begin
                if (r_i) begin
                    n_i     = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_i     = 1'b1;
                    n_state = S_OS;
                end
            end
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    case (r_state)
                        S_HID: begin
                            n_k = !r_k;
                            if (r_k) begin
                                n_state = S_HACT;
                            end
                        end
                        S_OSUM: begin
                            if (r_j == J_LAST) begin
                                n_j     = '0;
                                n_state = S_OACT;
                            end else begin
                                n_j = r_j + 1'b1;
                            end
                        end
                        S_TGT: n_state = S_DP;
                        S_DP:  n_state = S_DD;
                        S_DD: begin
                            n_i     = !r_i;
                            n_state = r_i ? S_ERR : S_DP;
                        end
                        S_ERR: begin
                            n_i = !r_i;
                            if (r_i) begin
                                n_state = S_HQ;
                            end
                        end
                        S_HQ: n_state = S_HG;
                        S_HG: n_state = S_HS;
                        S_HS: n_state = S_HW;
                        S_HW: begin
                            n_k = !r_k;
                            if (r_k) begin
                                n_state = S_HB;
                            end
                        end
                        S_OS: n_state = S_OW;
                        S_OW: begin
                            if (r_j == J_LAST) begin
                                n_j     = '0;
                                n_state = S_OB;
                            end else begin
                                n_j = r_j + 1'b1;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
        endcase
    end

    // Operand selection, multiplier control and weight port.
    always_comb begin
        w_a     = '0;
        w_b     = '0;
        w_mac   = '0;
        w_wr    = '0;
        w_wdata = D_W'(i_weight_value);
        w_sel   = 0;
        case (r_state)
            S_IDLE: begin
                w_wr.we = w_accept && (i_action == ACT_LOAD) && w_idx_ok;
            end
            S_HID: begin
                w_sel         = 2 * int'(r_j) + int'(r_k);
                w_a           = A_W'(w_rdata);
                w_b           = {2'b0, w_x};
                w_mac.mul_en  = !r_ph;
                w_mac.acc_en  = r_ph;
                w_mac.acc_clr = !r_k;
            end
            S_HACT: w_sel = 2 * H + int'(r_j);
            S_OSUM: begin
                w_sel         = 3 * H + int'(r_i) * H + int'(r_j);
                w_a           = A_W'(w_rdata);
                w_b           = {2'b0, w_hj};
                w_mac.mul_en  = !r_ph;
                w_mac.acc_en  = r_ph;
                w_mac.acc_clr = (r_j == '0);
            end
            S_OACT: w_sel = 5 * H + int'(r_i);
            S_TGT: begin
                w_a          = A_W'($signed({1'b0, r_l}) - $signed({1'b0, r_r}));
                w_b          = {2'b0, r_kp};
                w_mac.mul_en = !r_ph;
            end
            S_DP: begin
                w_a          = A_W'($signed({1'b0, w_oi}));
                w_b          = {1'b0, SIG_ONE - {1'b0, w_oi}};
                w_mac.mul_en = !r_ph;
            end
            S_DD: begin
                w_a          = A_W'($signed({1'b0, w_oi}) - $signed({1'b0, r_t[r_i]}));
                w_b          = {3'b0, r_p};
                w_mac.mul_en = !r_ph;
            end
            S_ERR: begin
                w_sel         = 3 * H + int'(r_i) * H + int'(r_j);
                w_a           = A_W'(w_rdata);
                w_b           = B_W'(r_d[r_i]);
                w_mac.mul_en  = !r_ph;
                w_mac.acc_en  = r_ph;
                w_mac.acc_clr = !r_i;
            end
            S_HQ: begin
                w_a          = A_W'($signed({1'b0, w_hj}));
                w_b          = {1'b0, SIG_ONE - {1'b0, w_hj}};
                w_mac.mul_en = !r_ph;
            end
            S_HG: begin
                w_a          = $signed(w_acc_hi[A_W-1:0]);
                w_b          = {3'b0, r_p};
                w_mac.mul_en = !r_ph;
            end
            S_HS: begin
                w_a          = r_g;
                w_b          = {2'b0, r_lr};
                w_mac.mul_en = !r_ph;
            end
            S_HW: begin
                w_sel        = 2 * int'(r_j) + int'(r_k);
                w_a          = r_s;
                w_b          = {2'b0, w_x};
                w_mac.mul_en = !r_ph;
                w_wr.we      = r_ph;
                w_wr.sub     = 1'b1;
                w_wdata      = D_W'(w_prod_hi);
            end
            S_HB: begin
                w_sel    = 2 * H + int'(r_j);
                w_wr.we  = 1'b1;
                w_wr.sub = 1'b1;
                w_wdata  = D_W'(r_s);
            end
            S_OS: begin
                w_a          = A_W'(r_d[r_i]);
                w_b          = {2'b0, r_lr};
                w_mac.mul_en = !r_ph;
            end
            S_OW: begin
                w_sel        = 3 * H + int'(r_i) * H + int'(r_j);
                w_a          = r_s;
                w_b          = {2'b0, w_hj};
                w_mac.mul_en = !r_ph;
                w_wr.we      = r_ph;
                w_wr.sub     = 1'b1;
                w_wdata      = D_W'(w_prod_hi);
            end
            S_OB: begin
                w_sel    = 5 * H + int'(r_i);
                w_wr.we  = 1'b1;
                w_wr.sub = 1'b1;
                w_wdata  = D_W'(r_s);
            end
            default: begin
                w_sel = 0;
            end
        endcase
        w_addr = (r_state == S_IDLE) ? AD_W'(i_weight_index) : AD_W'(w_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_i     <= 1'b0;
            r_j     <= '0;
            r_k     <= 1'b0;
            r_ov    <= 1'b0;
            r_lr    <= INIT_RATE_RST;
            r_kp    <= GAIN_KP_RST;
            r_off   <= OFFSET_RST;
            r_init  <= INIT_RATE_RST;
            r_step  <= RATE_STEP_RST;
            r_floor <= RATE_FLOOR_RST;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (w_accept && i_action == ACT_LOAD) begin
                r_lr <= r_init;
            end else if (w_accept && i_action == ACT_EPOCH && r_lr > r_floor) begin
                r_lr <= (r_lr > r_step) ? (r_lr - r_step) : 16'd0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN_KP:       r_kp    <= i_cfg_data;
                    REG_TARGET_OFFSET: r_off   <= i_cfg_data[6:0];
                    REG_INITIAL_RATE:  r_init  <= i_cfg_data;
                    REG_RATE_STEP:     r_step  <= i_cfg_data;
                    REG_RATE_FLOOR:    r_floor <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act    <= t_action'(i_action);
            r_l      <= i_left_reading;
            r_r      <= i_right_reading;
            r_spd[0] <= 7'd0;
            r_spd[1] <= 7'd0;
        end
        if (r_state == S_HACT) begin
            r_h[r_j] <= w_sig;
        end
        if (r_state == S_OACT) begin
            r_o[r_i]   <= w_sig;
            r_spd[r_i] <= w_spd[22:16];
        end
        if (r_ph) begin
            case (r_state)
                S_TGT: begin
                    r_t[0] <= f_target(w_off - w_ke);
                    r_t[1] <= f_target(w_off + w_ke);
                end
                S_DP, S_HQ: r_p      <= w_prod[30:16];
                S_DD:       r_d[r_i] <= w_prod_hi[15:0];
                S_HG:       r_g      <= w_prod_hi[A_W-1:0];
                S_HS, S_OS: r_s      <= w_prod_hi[A_W-1:0];
                default: ;
            endcase
        end
        if (w_push) begin
            r_out_l    <= r_spd[0];
            r_out_r    <= r_spd[1];
            r_out_rate <= r_lr;
        end
    end

    assign o_valid        = r_ov;
    assign o_left_speed   = r_out_l;
    assign o_right_speed  = r_out_r;
    assign o_current_rate = r_out_rate;

endmodule

// ===== sv/mlp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the perceptron trainer and their attachment to the top level.
module mlp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [6:0] o_left_speed,
    input logic [6:0] o_right_speed,
    input logic [15:0] o_current_rate
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("Result beat dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_left_speed) && $stable(o_right_speed)
            && $stable(o_current_rate))
        else $error("Result beat changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Input taken again before the previous beat was processed.");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_speed <= 7'd99) && (o_right_speed <= 7'd99))
        else $error("Speed out of range.");

endmodule

bind mlp_two_three_two_backprop mlp_checker u_mlp_checker (.*);

// ===== bench/mlp_two_three_two_backprop_tb.sv =====
`timescale 1ns / 1ps
// Randomized and directed self-checking testbench for the backpropagation perceptron.
module mlp_two_three_two_backprop_tb;
    import mlp_pkg::*;

    localparam int NSLOT = 17;
    localparam int WATCH_LIMIT = 40000;

    typedef struct {
        t_action act;
        logic [7:0] left;
        logic [7:0] right;
        logic [4:0] idx;
        logic signed [23:0] wval;
    } t_item;

    typedef struct {
        logic [6:0] ls;
        logic [6:0] rs;
        logic [15:0] rate;
    } t_speeds;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_action = '0;
    logic [7:0] i_left_reading = '0;
    logic [7:0] i_right_reading = '0;
    logic [4:0] i_weight_index = '0;
    logic signed [23:0] i_weight_value = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [6:0] o_left_speed;
    logic [6:0] o_right_speed;
    logic [15:0] o_current_rate;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    mlp_two_three_two_backprop DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_item pending_items[$];
    t_speeds speeds_due[$];
    longint weights[NSLOT];
    longint rate_now, kp_gain, offset_speed, rate_init, rate_dec, rate_min;
    int errs = 0;
    int send_idle = 0;
    int rx_stall = 0;
    int rx_hold = 0;
    bit running = 0;
    bit sending = 0;
    int beats_in = 0;
    int beats_out = 0;
    int trains = 0;
    int watch = 0;

    function automatic longint fl16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint wsat(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint sigmoid_q16(longint x);
        longint m, y;
        m = x < 0 ? -x : x;
        if (m >= 327680) y = 65536;
        else if (m >= 155648) y = (m >>> 5) + 55296;
        else if (m >= 65536) y = (m >>> 3) + 40960;
        else y = (m >>> 2) + 32768;
        if (x < 0) y = 65536 - y;
        return y > 65535 ? 65535 : y;
    endfunction

    function automatic longint target_q16(longint v);
        longint sp;
        if (v < 0) return 0;
        sp = v >>> 16;
        if (sp > 100) sp = 100;
        sp = (sp * 65536) / 100;
        return sp > 65535 ? 65535 : sp;
    endfunction

    function automatic t_speeds network_step(t_item it);
        t_speeds res;
        longint x[2], h[3], o[2], t[2], d[2], oldw[2][3];
        longint acc, s, err, g, e;
        res.ls = '0;
        res.rs = '0;
        if (it.act == ACT_LOAD) begin
            if (it.idx < NSLOT) weights[it.idx] = wsat(longint'(it.wval));
            rate_now = rate_init;
        end else if (it.act == ACT_EPOCH) begin
            if (rate_now > rate_min) rate_now = rate_now > rate_dec ? rate_now - rate_dec : 0;
        end else begin
            x[0] = longint'(it.left) * 257;
            x[1] = longint'(it.right) * 257;
            for (int j = 0; j < 3; j++)
                h[j] = sigmoid_q16(fl16(weights[2*j] * x[0] + weights[2*j+1] * x[1])
                                   + weights[6+j]);
            for (int i = 0; i < 2; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) acc += weights[9+3*i+j] * h[j];
                o[i] = sigmoid_q16(fl16(acc) + weights[15+i]);
            end
            res.ls = 7'((o[0] * 100) >>> 16);
            res.rs = 7'((o[1] * 100) >>> 16);
            if (it.act == ACT_TRAIN) begin
                e = longint'(it.left) - longint'(it.right);
                t[0] = target_q16(offset_speed * 65536 - kp_gain * e);
                t[1] = target_q16(offset_speed * 65536 + kp_gain * e);
                for (int i = 0; i < 2; i++) begin
                    d[i] = fl16((o[i] - t[i]) * fl16(o[i] * (65536 - o[i])));
                    s = fl16(rate_now * d[i]);
                    for (int j = 0; j < 3; j++) begin
                        oldw[i][j] = weights[9+3*i+j];
                        weights[9+3*i+j] = wsat(oldw[i][j] - fl16(s * h[j]));
                    end
                    weights[15+i] = wsat(weights[15+i] - s);
                end
                for (int j = 0; j < 3; j++) begin
                    err = fl16(d[0] * oldw[0][j] + d[1] * oldw[1][j]);
                    g = fl16(err * fl16(h[j] * (65536 - h[j])));
                    s = fl16(rate_now * g);
                    weights[2*j] = wsat(weights[2*j] - fl16(s * x[0]));
                    weights[2*j+1] = wsat(weights[2*j+1] - fl16(s * x[1]));
                    weights[6+j] = wsat(weights[6+j] - s);
                end
            end
        end
        res.rate = 16'(rate_now);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_item it;
        if (running) begin
            if (i_valid && o_ready) begin
                it.act = t_action'(i_action);
                it.left = i_left_reading;
                it.right = i_right_reading;
                it.idx = i_weight_index;
                it.wval = i_weight_value;
                speeds_due.push_back(network_step(it));
                beats_in++;
                if (it.act == ACT_TRAIN) trains++;
                sending = 0;
            end
            if (!sending && pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                it = pending_items.pop_front();
                i_action <= it.act;
                i_left_reading <= it.left;
                i_right_reading <= it.right;
                i_weight_index <= it.idx;
                i_weight_value <= it.wval;
                sending = 1;
            end
            i_valid <= sending;
        end
    end

    always @(posedge i_clk) begin
        t_speeds want;
        if (running) begin
            if (o_valid && i_ready) begin
                beats_out++;
                if (speeds_due.size() == 0) begin
                    errs++;
                    $error("result beat with no prediction waiting");
                end else begin
                    want = speeds_due.pop_front();
                    if (o_left_speed !== want.ls) begin
                        errs++;
                        $error("left_speed: expected %0d, got %0d", want.ls, o_left_speed);
                    end
                    if (o_right_speed !== want.rs) begin
                        errs++;
                        $error("right_speed: expected %0d, got %0d", want.rs, o_right_speed);
                    end
                    if (o_current_rate !== want.rate) begin
                        errs++;
                        $error("current_rate: expected %0d, got %0d", want.rate,
                               o_current_rate);
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= $urandom_range(99) >= rx_stall;
            end
        end
    end

    always @(posedge i_clk) begin
        if (running) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) watch <= 0;
            else watch <= watch + 1;
            if (watch >= WATCH_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic add_item(t_action act, int left, int right, int idx, int wval);
        t_item it;
        it.act = act;
        it.left = 8'(left);
        it.right = 8'(right);
        it.idx = 5'(idx);
        it.wval = 24'(wval);
        pending_items.push_back(it);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 16'(data);
        case (idx)
            REG_GAIN_KP: kp_gain = data & 16'hFFFF;
            REG_TARGET_OFFSET: offset_speed = data & 7'h7F;
            REG_INITIAL_RATE: rate_init = data & 16'hFFFF;
            REG_RATE_STEP: rate_dec = data & 16'hFFFF;
            default: rate_min = data & 16'hFFFF;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || sending || speeds_due.size() > 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic int some_weight();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4) return -8388608;
        if (pick < 8) return 8388607;
        if (pick < 14) return int'($urandom);
        return $urandom_range(393216) - 196608;
    endfunction

    task automatic load_all();
        for (int k = 0; k < NSLOT; k++) add_item(ACT_LOAD, 0, 0, k, some_weight());
    endtask

    initial begin
        int pick;
        for (int k = 0; k < NSLOT; k++) weights[k] = 0;
        rate_now = INIT_RATE_RST;
        kp_gain = GAIN_KP_RST;
        offset_speed = OFFSET_RST;
        rate_init = INIT_RATE_RST;
        rate_dec = RATE_STEP_RST;
        rate_min = RATE_FLOOR_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        running = 1;

        // Directed: full load, sensor extremes, out-of-range slots, rate decay to zero.
        for (int k = 0; k < NSLOT; k++)
            add_item(ACT_LOAD, 0, 0, k, (k % 2) ? 40000 : -30000);
        add_item(ACT_INFER, 0, 0, 0, 0);
        add_item(ACT_INFER, 255, 255, 0, 0);
        add_item(ACT_TRAIN, 255, 0, 0, 0);
        add_item(ACT_TRAIN, 0, 255, 0, 0);
        add_item(ACT_LOAD, 0, 0, 17, 8388607);
        add_item(ACT_LOAD, 0, 0, 31, -8388608);
        add_item(ACT_EPOCH, 0, 0, 0, 0);
        drain();
        cfg_write(REG_RATE_STEP, 65535);
        cfg_write(REG_RATE_FLOOR, 0);
        cfg_write(REG_TARGET_OFFSET, 127);
        cfg_write(REG_GAIN_KP, 65535);
        add_item(ACT_EPOCH, 0, 0, 0, 0);
        add_item(ACT_EPOCH, 0, 0, 0, 0);
        add_item(ACT_TRAIN, 200, 10, 0, 0);
        add_item(ACT_LOAD, 0, 0, 16, 8388607);
        add_item(ACT_LOAD, 0, 0, 15, -8388608);
        add_item(ACT_TRAIN, 10, 200, 0, 0);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    cfg_write(REG_GAIN_KP, GAIN_KP_RST);
                    cfg_write(REG_TARGET_OFFSET, OFFSET_RST);
                    cfg_write(REG_INITIAL_RATE, INIT_RATE_RST);
                    cfg_write(REG_RATE_STEP, RATE_STEP_RST);
                    cfg_write(REG_RATE_FLOOR, RATE_FLOOR_RST);
                end
                3: begin
                    cfg_write(REG_GAIN_KP, 0);
                    cfg_write(REG_TARGET_OFFSET, 0);
                    cfg_write(REG_INITIAL_RATE, 0);
                    cfg_write(REG_RATE_STEP, 0);
                    cfg_write(REG_RATE_FLOOR, 0);
                end
                5: begin
                    cfg_write(REG_GAIN_KP, 65535);
                    cfg_write(REG_TARGET_OFFSET, 100);
                    cfg_write(REG_INITIAL_RATE, 65535);
                    cfg_write(REG_RATE_STEP, 4000);
                    cfg_write(REG_RATE_FLOOR, 65535);
                end
                default: begin
                    cfg_write(REG_GAIN_KP, $urandom_range(65535));
                    cfg_write(REG_TARGET_OFFSET, $urandom_range(127));
                    cfg_write(REG_INITIAL_RATE, $urandom_range(65535));
                    cfg_write(REG_RATE_STEP, $urandom_range(8000));
                    cfg_write(REG_RATE_FLOOR, $urandom_range(65535));
                end
            endcase
            case (p % 4)
                0: begin send_idle = 0; rx_stall = 0; end
                1: begin send_idle = 76; rx_stall = 0; end
                2: begin send_idle = 0; rx_stall = 76; end
                default: begin send_idle = 18; rx_stall = 18; end
            endcase
            if (p == 4) rx_hold = 3000;
            load_all();
            for (int n = 0; n < 208; n++) begin
                pick = $urandom_range(99);
                if (pick < 45)
                    add_item(ACT_TRAIN, $urandom_range(255), $urandom_range(255), 0, 0);
                else if (pick < 75)
                    add_item(ACT_INFER, $urandom_range(255), $urandom_range(255),
                             $urandom_range(31), int'($urandom));
                else if (pick < 87)
                    add_item(ACT_EPOCH, $urandom_range(255), $urandom_range(255), 0, 0);
                else
                    add_item(ACT_LOAD, $urandom_range(255), $urandom_range(255),
                             $urandom_range(31), some_weight());
            end
            drain();
        end

        if (speeds_due.size() != 0) begin
            errs++;
            $error("%0d predicted results never arrived", speeds_due.size());
        end
        $display("Covered %0d input beats (%0d training steps) and %0d result beats,",
                 beats_in, trains, beats_out);
        $display("across reset, zero, maximum and random register settings.");
        if (errs == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
